// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DZHF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DZHF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dzhf_pkg.sv =====
// ----------------------------------------------------------------------------
// dzhf_pkg
// Types and constants of the z-buffer depth projection / hole-fill block.
// ----------------------------------------------------------------------------
package dzhf_pkg;

   typedef struct packed {
      logic               op;
      logic               point_valid;
      logic signed [23:0] lidar_x;
      logic signed [23:0] lidar_y;
      logic signed [23:0] lidar_z;
      logic signed [39:0] cam_x;
      logic signed [39:0] cam_y;
      logic signed [23:0] cam_z;
   } req_type;

   typedef struct packed {
      logic [22:0] depth;
      logic        was_measured;
      logic        was_filled;
      logic [8:0]  pixel_col;
      logic [8:0]  pixel_row;
      logic        last_pixel;
   } rsp_type;

   typedef struct packed {
      logic        meas;
      logic [22:0] depth;
   } cell_type;

   localparam int DEPTH_W = 23;
   localparam int ALU_W   = 50;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [CSR_AW-1:0] CSR_COLS = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_ROWS = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_MINR = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_MINN = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_TOL  = 3'd4;

   localparam logic [9:0]  RST_COLS = 10'd400;
   localparam logic [9:0]  RST_ROWS = 10'd324;
   localparam logic [31:0] RST_MINR = 32'd250000;
   localparam logic [3:0]  RST_MINN = 4'd3;
   localparam logic [22:0] RST_TOL  = 23'd300;

   localparam logic       OP_LOAD = 1'b0;
   localparam logic       OP_READ = 1'b1;

   typedef enum logic {ALU_SQUARE, ALU_CSUB} alu_op_type;

   typedef enum logic [1:0] {DIV_U, DIV_V, DIV_IDX} div_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SQ, ST_RCHK, ST_DIV, ST_DIVEND, ST_LRD, ST_LWR,
      ST_RSTART, ST_CRD, ST_CCHK, ST_NRD, ST_NACC, ST_FDEC, ST_OUT
   } state_type;

endpackage

// ===== rtl/dzhf_alu.sv =====
// ----------------------------------------------------------------------------
// dzhf_alu
// Shared arithmetic unit: squarer for the range test, compare-subtract for
// the restoring divider.
// ----------------------------------------------------------------------------
module dzhf_alu import dzhf_pkg::*; (
   input  alu_op_type         op,
   input  logic signed [23:0] sq_in,
   input  logic [ALU_W-1:0]   a,
   input  logic [ALU_W-1:0]   b,
   output logic [ALU_W-1:0]   result,
   output logic               ge
);

   logic signed [47:0] prod;
   logic [ALU_W-1:0]   diff;

   assign prod = sq_in * sq_in;
   assign diff = a - b;
   assign ge   = (a >= b);

   always_comb begin
      case (op)
         ALU_SQUARE: result = ALU_W'(unsigned'(prod));
         ALU_CSUB:   result = diff;
         default:    result = diff;
      endcase
   end

endmodule

// ===== rtl/dzhf_mem.sv =====
// ----------------------------------------------------------------------------
// dzhf_mem
// Single-write, single-read cell store with registered read data.
// ----------------------------------------------------------------------------
module dzhf_mem #(
   parameter int DEPTH = 262144,
   parameter int AW    = 18,
   parameter int DW    = 24
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] cell_mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         cell_mem[waddr] <= wdata;
      end
      rdata_ff <= cell_mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/depth_zbuffer_hole_fill_top.sv =====
// ----------------------------------------------------------------------------
// depth_zbuffer_hole_fill_top
// Z-buffered point projection into a depth image, raster readout with
// guarded 3x3 hole filling.
// ----------------------------------------------------------------------------
// One transaction at a time under a small sequencer. A load transaction
// (op 0) goes through the shared squarer for the range test, then two
// restoring divisions on the shared compare-subtract unit (one quotient
// bit a cycle, plus an overflow probe), then a read and a conditional
// write of the cell store. A dropped point returns to idle early. A
// readout transaction (op 1) does an index-to-column/row division on the
// same unit (skipped for the last pixel), a center read, and for an
// unmeasured pixel up to eight neighbour reads, all through the single
// read port. After reset and after the last pixel of an image the store
// is cleared one cell a cycle, during which req_ready stays low.
// Configuration writes are taken at any time. The result sits in an output
// register, so a load may be accepted while a readout result still waits.
// ----------------------------------------------------------------------------
module depth_zbuffer_hole_fill_top import dzhf_pkg::*; #(
   parameter int MAX_COLS = 512,
   parameter int MAX_ROWS = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int CIW   = $clog2(MAX_COLS);
   localparam int RIW   = $clog2(MAX_ROWS);
   localparam int CBW   = $clog2(MAX_COLS + 1);
   localparam int RBW   = $clog2(MAX_ROWS + 1);
   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int TW    = CBW + RBW;
   localparam int QW    = (CIW > RIW) ? CIW : RIW;
   localparam int SW    = $clog2(QW + 1);

   // configuration
   logic [9:0]          cols_ff, rows_ff;
   logic [31:0]         minr_ff;
   logic [3:0]          minn_ff;
   logic [DEPTH_W-1:0]  tol_ff;

   // sequencer and datapath
   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic [SW-1:0]       step_ff, step_in;
   logic [ALU_W-1:0]    acc_ff, acc_in, prod_ff, prod_in;
   logic [ALU_W-1:0]    rem_ff, rem_in, dvs_ff, dvs_in;
   logic [QW-1:0]       quo_ff, quo_in;
   logic                ovf_ff, ovf_in, neg_ff, neg_in;
   div_sel_type         sel_ff, sel_in;
   logic [CIW-1:0]      col_ff, col_in;
   logic [RIW-1:0]      row_ff, row_in;
   logic                active_ff, active_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic                last_ff, last_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [DEPTH_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, dep_ff, dep_in;
   logic [1:0]          nbr_r_ff, nbr_r_in, nbr_c_ff, nbr_c_in;
   logic                meas_ff, meas_in, filled_ff, filled_in;
   logic [AW-1:0]       clr_ff, clr_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // shared unit and store
   alu_op_type          alu_op;
   logic signed [23:0]  alu_sq;
   logic [ALU_W-1:0]    alu_res;
   logic                alu_ge;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic [$bits(cell_type)-1:0] mem_wdata, mem_rdata;
   cell_type            rd_cell;

   // derived terms
   logic [CBW-1:0]      cols_eff;
   logic [RBW-1:0]      rows_eff;
   logic [TW-1:0]       total;
   logic [AW-1:0]       idx_eff, ctr_addr, nbr_addr;
   logic                req_fire, rsp_free, cz_pos, range_ok, div_done, quo_ok;
   logic                last_now, clr_done, load_write, nbr_ok, nbr_done;
   logic [SW-1:0]       div_qb;
   logic [39:0]         cx_abs, cy_abs;
   logic [ALU_W-1:0]    num_u, num_v, dvs_u, dvs_v, dvs_idx;
   logic [RIW:0]        nbr_row_t;
   logic [CIW:0]        nbr_col_t;
   logic [RIW-1:0]      nbr_row;
   logic [CIW-1:0]      nbr_col;
   logic [DEPTH_W-1:0]  cz_mag;

   dzhf_alu u_alu (
      .op     (alu_op),
      .sq_in  (alu_sq),
      .a      (rem_ff),
      .b      (dvs_ff),
      .result (alu_res),
      .ge     (alu_ge)
   );

   dzhf_mem #(.DEPTH(CELLS), .AW(AW), .DW($bits(cell_type))) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rd_cell = cell_type'(mem_rdata);

   // clamp the image size to 1..MAX
   always_comb begin
      if (cols_ff == '0) begin
         cols_eff = CBW'(1);
      end else if (32'(cols_ff) > MAX_COLS) begin
         cols_eff = CBW'(MAX_COLS);
      end else begin
         cols_eff = CBW'(cols_ff);
      end
      if (rows_ff == '0) begin
         rows_eff = RBW'(1);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         rows_eff = RBW'(MAX_ROWS);
      end else begin
         rows_eff = RBW'(rows_ff);
      end
   end

   assign total    = TW'(cols_eff) * TW'(rows_eff);
   assign idx_eff  = active_ff ? idx_ff : '0;
   assign last_now = (32'(idx_eff) >= (32'(total) - 32'd1));

   assign req_fire = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign clr_done = (clr_ff == AW'(CELLS - 1));

   // projection operands: round(n/d) = floor((2|n| + d) / 2d)
   assign cz_pos = !req_ff.cam_z[23] && (req_ff.cam_z != '0);
   assign cz_mag = req_ff.cam_z[DEPTH_W-1:0];
   assign cx_abs = req_ff.cam_x[39] ? 40'(-req_ff.cam_x) : 40'(req_ff.cam_x);
   assign cy_abs = req_ff.cam_y[39] ? 40'(-req_ff.cam_y) : 40'(req_ff.cam_y);
   assign num_u  = ALU_W'({cx_abs, 1'b0}) + ALU_W'(cz_mag);
   assign num_v  = ALU_W'({cy_abs, 1'b0}) + ALU_W'(cz_mag);
   assign dvs_u  = ALU_W'({cz_mag, 1'b0}) << CIW;
   assign dvs_v  = ALU_W'({cz_mag, 1'b0}) << RIW;
   assign dvs_idx = ALU_W'(cols_eff) << RIW;

   assign range_ok = (acc_ff >= ALU_W'(minr_ff));
   assign div_qb   = (sel_ff == DIV_U) ? SW'(CIW) : SW'(RIW);
   assign div_done = (step_ff == div_qb);

   // quotient fits, sign allows it, and it lands inside the image
   always_comb begin
      quo_ok = !ovf_ff && !(neg_ff && (quo_ff != '0));
      if (sel_ff == DIV_U) begin
         quo_ok = quo_ok && (32'(quo_ff) < 32'(cols_eff));
      end else begin
         quo_ok = quo_ok && (32'(quo_ff) < 32'(rows_eff));
      end
   end

   assign ctr_addr   = AW'(row_ff) * AW'(MAX_COLS) + AW'(col_ff);
   assign load_write = !rd_cell.meas || (cz_mag < rd_cell.depth);

   // neighbour walk: offsets 0..2 stand for -1..+1
   assign nbr_row_t = (RIW+1)'(row_ff) + (RIW+1)'(nbr_r_ff);
   assign nbr_col_t = (CIW+1)'(col_ff) + (CIW+1)'(nbr_c_ff);
   assign nbr_row   = RIW'(nbr_row_t - (RIW+1)'(1));
   assign nbr_col   = CIW'(nbr_col_t - (CIW+1)'(1));
   assign nbr_ok    = (nbr_row_t != '0) && (nbr_col_t != '0)
                   && (32'(nbr_row_t) - 32'd1 < 32'(rows_eff))
                   && (32'(nbr_col_t) - 32'd1 < 32'(cols_eff))
                   && !((nbr_r_ff == 2'd1) && (nbr_c_ff == 2'd1));
   assign nbr_done  = (nbr_r_ff == 2'd2) && (nbr_c_ff == 2'd2);
   assign nbr_addr  = AW'(nbr_row) * AW'(MAX_COLS) + AW'(nbr_col);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.op == OP_READ) begin
                  state_in = ST_RSTART;
               end else if (!active_ff && req_data.point_valid) begin
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ:     if (step_ff == SW'(3)) state_in = ST_RCHK;
         ST_RCHK:   state_in = (range_ok && cz_pos) ? ST_DIV : ST_IDLE;
         ST_DIV:    if (div_done) state_in = ST_DIVEND;
         ST_DIVEND: begin
            case (sel_ff)
               DIV_U:   state_in = quo_ok ? ST_DIV : ST_IDLE;
               DIV_V:   state_in = quo_ok ? ST_LRD : ST_IDLE;
               DIV_IDX: state_in = ST_CRD;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_LRD:    state_in = ST_LWR;
         ST_LWR:    state_in = ST_IDLE;
         ST_RSTART: state_in = last_now ? ST_CRD : ST_DIV;
         ST_CRD:    state_in = ST_CCHK;
         ST_CCHK:   state_in = rd_cell.meas ? ST_OUT : ST_NRD;
         ST_NRD: begin
            if (nbr_ok) begin
               state_in = ST_NACC;
            end else if (nbr_done) begin
               state_in = ST_FDEC;
            end
         end
         ST_NACC:   state_in = nbr_done ? ST_FDEC : ST_NRD;
         ST_FDEC:   state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_free) state_in = last_ff ? ST_CLEAR : ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath and store control ----------------
   always_comb begin
      req_in = req_ff;     step_in = step_ff;   acc_in = acc_ff;   prod_in = prod_ff;
      rem_in = rem_ff;     dvs_in = dvs_ff;     quo_in = quo_ff;   ovf_in = ovf_ff;
      neg_in = neg_ff;     sel_in = sel_ff;     col_in = col_ff;   row_in = row_ff;
      active_in = active_ff;  idx_in = idx_ff;  last_in = last_ff; cnt_in = cnt_ff;
      lo_in = lo_ff;       hi_in = hi_ff;       dep_in = dep_ff;
      nbr_r_in = nbr_r_ff; nbr_c_in = nbr_c_ff; meas_in = meas_ff; filled_in = filled_ff;
      clr_in = clr_ff;     rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      alu_op = ALU_CSUB;
      case (step_ff[1:0])
         2'd0:    alu_sq = req_ff.lidar_x;
         2'd1:    alu_sq = req_ff.lidar_y;
         default: alu_sq = req_ff.lidar_z;
      endcase
      mem_we    = 1'b0;
      mem_waddr = ctr_addr;
      mem_wdata = '0;
      mem_raddr = ctr_addr;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               req_in  = req_data;
               step_in = '0;
            end
         end
         ST_SQ: begin
            alu_op  = ALU_SQUARE;
            prod_in = alu_res;
            acc_in  = (step_ff == '0) ? '0 : acc_ff + prod_ff;
            step_in = step_ff + SW'(1);
         end
         ST_RCHK: begin
            sel_in  = DIV_U;
            rem_in  = num_u;
            dvs_in  = dvs_u;
            neg_in  = req_ff.cam_x[39];
            quo_in  = '0;
            ovf_in  = 1'b0;
            step_in = '0;
         end
         ST_DIV: begin
            // step 0 probes for quotient overflow, then one bit a cycle
            if (step_ff == '0) begin
               ovf_in = alu_ge;
            end else begin
               if (alu_ge) rem_in = alu_res;
               quo_in = {quo_ff[QW-2:0], alu_ge};
            end
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff + SW'(1);
         end
         ST_DIVEND: begin
            case (sel_ff)
               DIV_U: begin
                  col_in  = CIW'(quo_ff);
                  sel_in  = DIV_V;
                  rem_in  = num_v;
                  dvs_in  = dvs_v;
                  neg_in  = req_ff.cam_y[39];
                  quo_in  = '0;
                  ovf_in  = 1'b0;
                  step_in = '0;
               end
               DIV_V:   row_in = RIW'(quo_ff);
               DIV_IDX: begin
                  row_in = RIW'(quo_ff);
                  col_in = CIW'(rem_ff);
               end
               default: ;
            endcase
         end
         ST_LRD: mem_raddr = ctr_addr;
         ST_LWR: begin
            if (load_write) begin
               mem_we    = 1'b1;
               mem_wdata = {1'b1, cz_mag};
            end
         end
         ST_RSTART: begin
            active_in = 1'b1;
            idx_in    = idx_eff;
            last_in   = last_now;
            if (last_now) begin
               col_in = CIW'(cols_eff - CBW'(1));
               row_in = RIW'(rows_eff - RBW'(1));
            end else begin
               sel_in  = DIV_IDX;
               rem_in  = ALU_W'(idx_eff);
               dvs_in  = dvs_idx;
               neg_in  = 1'b0;
               quo_in  = '0;
               ovf_in  = 1'b0;
               step_in = '0;
            end
         end
         ST_CRD: mem_raddr = ctr_addr;
         ST_CCHK: begin
            meas_in   = rd_cell.meas;
            dep_in    = rd_cell.depth;
            filled_in = 1'b0;
            cnt_in    = '0;
            nbr_r_in  = '0;
            nbr_c_in  = '0;
         end
         ST_NRD: begin
            mem_raddr = nbr_addr;
            if (!nbr_ok && !nbr_done) begin
               nbr_c_in = (nbr_c_ff == 2'd2) ? 2'd0 : nbr_c_ff + 2'd1;
               if (nbr_c_ff == 2'd2) nbr_r_in = nbr_r_ff + 2'd1;
            end
         end
         ST_NACC: begin
            if (rd_cell.meas) begin
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == '0) begin
                  lo_in = rd_cell.depth;
                  hi_in = rd_cell.depth;
               end else begin
                  if (rd_cell.depth < lo_ff) lo_in = rd_cell.depth;
                  if (rd_cell.depth > hi_ff) hi_in = rd_cell.depth;
               end
            end
            nbr_c_in = (nbr_c_ff == 2'd2) ? 2'd0 : nbr_c_ff + 2'd1;
            if (nbr_c_ff == 2'd2) nbr_r_in = nbr_r_ff + 2'd1;
         end
         ST_FDEC: begin
            filled_in = (cnt_ff != '0) && (cnt_ff >= minn_ff) && ((hi_ff - lo_ff) <= tol_ff);
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_in.depth        = meas_ff ? dep_ff : (filled_ff ? hi_ff : '0);
               rsp_in.was_measured = meas_ff;
               rsp_in.was_filled   = filled_ff;
               rsp_in.pixel_col    = 9'(col_ff);
               rsp_in.pixel_row    = 9'(row_ff);
               rsp_in.last_pixel   = last_ff;
               rsp_valid_in        = 1'b1;
               if (last_ff) begin
                  active_in = 1'b0;
                  idx_in    = '0;
                  clr_in    = '0;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;    step_ff  <= step_in;  acc_ff   <= acc_in;
      prod_ff   <= prod_in;   rem_ff   <= rem_in;   dvs_ff   <= dvs_in;
      quo_ff    <= quo_in;    ovf_ff   <= ovf_in;   neg_ff   <= neg_in;
      sel_ff    <= sel_in;    col_ff   <= col_in;   row_ff   <= row_in;
      last_ff   <= last_in;   cnt_ff   <= cnt_in;   lo_ff    <= lo_in;
      hi_ff     <= hi_in;     dep_ff   <= dep_in;   nbr_r_ff <= nbr_r_in;
      nbr_c_ff  <= nbr_c_in;  meas_ff  <= meas_in;  filled_ff <= filled_in;
      rsp_ff    <= rsp_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= RST_COLS;
         rows_ff <= RST_ROWS;
         minr_ff <= RST_MINR;
         minn_ff <= RST_MINN;
         tol_ff  <= RST_TOL;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLS: cols_ff <= csr_wdata[9:0];
            CSR_ROWS: rows_ff <= csr_wdata[9:0];
            CSR_MINR: minr_ff <= csr_wdata;
            CSR_MINN: minn_ff <= csr_wdata[3:0];
            CSR_TOL:  tol_ff  <= csr_wdata[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

// ===== rtl/dzhf_checker.sv =====
// ----------------------------------------------------------------------------
// dzhf_checker
// Port-level checks of the depth projection block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dzhf_checker import dzhf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `DZHF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped or changed while stalled")
   `DZHF_ASSERT_NEXT(a_read_busy, clock, reset, req_valid && req_ready && req_data.op, !req_ready, "readout transaction did not occupy the sequencer")
   `DZHF_ASSERT_SAME(a_clear_after_last, clock, reset, $rose(rsp_valid) && rsp_data.last_pixel, !req_ready, "ready during store clear")
   `DZHF_ASSERT_NEXT(a_load_silent, clock, reset, req_valid && req_ready && !req_data.op, !$rose(rsp_valid), "load transaction produced a result")

endmodule

bind depth_zbuffer_hole_fill_top dzhf_checker u_dzhf_checker (.*);

// ===== bench/tb_depth_zbuffer_hole_fill_top.sv =====
// ----------------------------------------------------------------------------
// tb_depth_zbuffer_hole_fill_top
// Self-checking bench for the z-buffer projection / hole-fill block.
// ----------------------------------------------------------------------------
// Directed transactions come first: point drop cases, z-buffer tie and
// nearer/farther depths, rounding, a readout with a size change halfway
// through, and a forced end of image. Three random images follow, built
// from targeted points with holes left in the image, plus noise points.
// Responses are checked against a behavioral predictor here or a typed one.
// ----------------------------------------------------------------------------
module tb_depth_zbuffer_hole_fill_top;
   import dzhf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCOLS = 512;
   localparam int NROWS = 512;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_we;
   logic [CSR_AW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wdata;

   depth_zbuffer_hole_fill_top #(.MAX_COLS(NCOLS), .MAX_ROWS(NROWS)) dut (.*);

   // Predictor state: own copy of the registers and the depth image.
   logic [9:0]  cols_reg;
   logic [9:0]  rows_reg;
   logic [31:0] minr_reg;
   logic [3:0]  minn_reg;
   logic [22:0] tol_reg;
   logic [22:0] zbuf[int];     // an entry exists only for a measured cell
   int          raster_pos;
   bit          reading_out;

   rsp_type     expected_pixels[$];
   int          mismatches;
   int          pixels_checked;
   int          filled_seen;
   int          points_sent;
   int          tx_idle_pct;
   int          rx_idle_pct;

   // Directed table row: either a register write or a transaction, the
   // latter optionally with a hand-typed response.
   typedef struct {
      bit                is_reg;
      logic [CSR_AW-1:0] idx;
      logic [31:0]       val;
      req_type           pt;
      bit                typed;
      rsp_type           want;
   } step_type;

   step_type steps[$];

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------
   function automatic int width_now();
      return (cols_reg == 0) ? 1 : ((cols_reg > NCOLS) ? NCOLS : int'(cols_reg));
   endfunction

   function automatic int height_now();
      return (rows_reg == 0) ? 1 : ((rows_reg > NROWS) ? NROWS : int'(rows_reg));
   endfunction

   // round half away from zero, den > 0
   function automatic longint div_round(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q   = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
   endfunction

   function automatic void project_point(req_type p);
      longint lx, ly, lz, cx, cy, cz, r2, u, v;
      int     a;
      if (!p.point_valid)
         return;
      lx = p.lidar_x;
      ly = p.lidar_y;
      lz = p.lidar_z;
      r2 = lx * lx + ly * ly + lz * lz;
      if (r2 < longint'({32'b0, minr_reg}))
         return;
      cz = p.cam_z;
      if (cz <= 0)
         return;
      cx = p.cam_x;
      cy = p.cam_y;
      u  = div_round(cx, cz);
      v  = div_round(cy, cz);
      if (u < 0 || u >= width_now() || v < 0 || v >= height_now())
         return;
      a = int'(v) * NCOLS + int'(u);
      if (!zbuf.exists(a) || cz[22:0] < zbuf[a])
         zbuf[a] = cz[22:0];
   endfunction

   function automatic rsp_type next_pixel();
      rsp_type     o;
      int          c, r, col, row, cnt, nr, nc;
      logic [22:0] lo, hi, d;
      c   = width_now();
      r   = height_now();
      o   = '0;
      cnt = 0;
      lo  = '0;
      hi  = '0;
      if (!reading_out) begin
         reading_out = 1'b1;
         raster_pos  = 0;
      end
      if (raster_pos >= c * r - 1) begin
         col = c - 1;
         row = r - 1;
         o.last_pixel = 1'b1;
      end else begin
         col = raster_pos % c;
         row = raster_pos / c;
      end
      o.pixel_col = col[8:0];
      o.pixel_row = row[8:0];
      if (zbuf.exists(row * NCOLS + col)) begin
         o.was_measured = 1'b1;
         o.depth        = zbuf[row * NCOLS + col];
      end else begin
         for (nr = row - 1; nr <= row + 1; nr++)
            for (nc = col - 1; nc <= col + 1; nc++) begin
               if (nr < 0 || nr >= r || nc < 0 || nc >= c)
                  continue;
               if (!zbuf.exists(nr * NCOLS + nc))
                  continue;
               d = zbuf[nr * NCOLS + nc];
               if (cnt == 0) begin
                  lo = d;
                  hi = d;
               end else begin
                  if (d < lo) lo = d;
                  if (d > hi) hi = d;
               end
               cnt++;
            end
         if (cnt > 0 && cnt >= minn_reg && (hi - lo) <= tol_reg) begin
            o.depth      = hi;
            o.was_filled = 1'b1;
         end
      end
      if (o.last_pixel) begin
         zbuf.delete();
         raster_pos  = 0;
         reading_out = 1'b0;
      end else begin
         raster_pos = (raster_pos + 1) & 32'h3FFFF;
      end
      return o;
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // Register write; caller makes sure the block is idle.
   task automatic write_reg(logic [CSR_AW-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_COLS: cols_reg = val[9:0];
         CSR_ROWS: rows_reg = val[9:0];
         CSR_MINR: minr_reg = val;
         CSR_MINN: minn_reg = val[3:0];
         CSR_TOL:  tol_reg  = val[22:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Drops valid, then waits until every outstanding response has drained.
   task automatic drain_pixels();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_pixels.size() != 0);
   endtask

   // Drain plus enough slack for a load still in flight.
   task automatic wait_quiet();
      drain_pixels();
      repeat (80) @(posedge clock);
   endtask

   // One request transaction; valid stays high afterward unless the next
   // call decides to idle. Prediction is done at the accepting edge.
   task automatic send_req(req_type p, bit typed = 1'b0, rsp_type want = '0);
      int gap;
      gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do
         @(posedge clock);
      while (!req_ready);
      if (p.op == OP_READ) begin
         if (typed) begin
            void'(next_pixel());
            expected_pixels = {expected_pixels, want};
         end else begin
            expected_pixels = {expected_pixels, next_pixel()};
         end
      end else begin
         if (!reading_out)
            project_point(p);
      end
      points_sent++;
      if (points_sent == 630) begin
         tx_idle_pct = 60;
         rx_idle_pct = 21;
      end else if (points_sent == 1260) begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus builders
   // -------------------------------------------------------------------------
   function automatic req_type read_req();
      req_type p;
      p    = '0;
      p.op = OP_READ;
      p.lidar_x = 24'($urandom);
      p.cam_y   = 40'({$urandom, $urandom});
      return p;
   endfunction

   function automatic req_type raw_point(logic [23:0] lx, logic [23:0] ly, logic [23:0] lz,
                                         logic [39:0] cx, logic [39:0] cy, logic [23:0] cz,
                                         logic ok = 1'b1);
      req_type p;
      p.op = OP_LOAD;
      p.point_valid = ok;
      p.lidar_x = lx;
      p.lidar_y = ly;
      p.lidar_z = lz;
      p.cam_x   = cx;
      p.cam_y   = cy;
      p.cam_z   = cz;
      return p;
   endfunction

   // Point landing on (u, v) at depth z, with a random sub-pixel offset.
   function automatic req_type aimed_point(int u, int v, int z);
      req_type p;
      longint  half;
      longint  lmag;
      half = (z - 1) / 2;
      lmag = $urandom_range(100000, 8388607);
      p = raw_point(24'($urandom_range(0, 1) ? -lmag : lmag), 24'($urandom), 24'($urandom),
                    40'(longint'(u) * z + longint'($urandom_range(0, 32'(2 * half))) - half),
                    40'(longint'(v) * z + longint'($urandom_range(0, 32'(2 * half))) - half),
                    24'(z));
      return p;
   endfunction

   function automatic void add_reg(logic [CSR_AW-1:0] idx, logic [31:0] val);
      step_type s;
      s = '{default: '0};
      s.is_reg = 1'b1;
      s.idx    = idx;
      s.val    = val;
      steps = {steps, s};
   endfunction

   function automatic void add_req(req_type p, bit typed = 1'b0, rsp_type want = '0);
      step_type s;
      s = '{default: '0};
      s.pt    = p;
      s.typed = typed;
      s.want  = want;
      steps = {steps, s};
   endfunction

   // Random image: loads aimed at non-hole cells, some broken, some noise,
   // then a full raster readout with a drain pause halfway.
   task automatic run_image(int c, int r, int nloads, logic [31:0] minr,
                            logic [3:0] minn, logic [22:0] tol);
      int      cells_in_use[$];
      int      i, pick, z, base;
      req_type p;
      wait_quiet();
      write_reg(CSR_COLS, c);
      write_reg(CSR_ROWS, r);
      write_reg(CSR_MINR, minr);
      write_reg(CSR_MINN, 32'(minn));
      write_reg(CSR_TOL, 32'(tol));
      for (i = 0; i < c * r; i++)
         if ($urandom_range(0, 99) >= 35)
            cells_in_use = {cells_in_use, i};
      if (cells_in_use.size() == 0)
         cells_in_use = {cells_in_use, 0};
      base = $urandom_range(1000, 8000000);
      for (i = 0; i < nloads; i++) begin
         pick = cells_in_use[$urandom_range(0, cells_in_use.size() - 1)];
         z = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8388607)
                                         : base + $urandom_range(0, 400);
         p = aimed_point(pick % c, pick / c, z);
         case ($urandom_range(0, 19))
            0: p.point_valid = 1'b0;
            1: p.cam_z = -p.cam_z;
            2: begin
               p.lidar_x = 24'($urandom_range(0, 300));
               p.lidar_y = 24'($urandom_range(0, 300));
               p.lidar_z = 24'($urandom_range(0, 300));
            end
            3, 4, 5: p = raw_point(24'($urandom), 24'($urandom), 24'($urandom),
                                   40'({$urandom, $urandom}), 40'({$urandom, $urandom}),
                                   24'($urandom), 1'($urandom));
            default: ;
         endcase
         send_req(p);
      end
      for (i = 0; i < c * r; i++) begin
         if (i == (c * r) / 2)
            drain_pixels();
         // an occasional load during readout must be ignored
         if ($urandom_range(0, 49) == 0)
            send_req(aimed_point(0, 0, 5000));
         send_req(read_req());
      end
   endtask

   // -------------------------------------------------------------------------
   // Response checker and receiver stalls
   // -------------------------------------------------------------------------
   task automatic report(string what, rsp_type want);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t MISMATCH %s: exp depth=%0d meas=%0b fill=%0b col=%0d row=%0d last=%0b",
                  $realtime, what, want.depth, want.was_measured, want.was_filled,
                  want.pixel_col, want.pixel_row, want.last_pixel,
                  " | got depth=%0d meas=%0b fill=%0b col=%0d row=%0d last=%0b",
                  rsp_data.depth, rsp_data.was_measured, rsp_data.was_filled,
                  rsp_data.pixel_col, rsp_data.pixel_row, rsp_data.last_pixel);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report("unexpected pixel", '0);
            end else begin
               want = expected_pixels.pop_front();
               pixels_checked++;
               if (rsp_data.was_filled)
                  filled_seen++;
               if (rsp_data.depth !== want.depth)
                  report("depth", want);
               else if (rsp_data.was_measured !== want.was_measured)
                  report("was_measured", want);
               else if (rsp_data.was_filled !== want.was_filled)
                  report("was_filled", want);
               else if (rsp_data.pixel_col !== want.pixel_col)
                  report("pixel_col", want);
               else if (rsp_data.pixel_row !== want.pixel_row)
                  report("pixel_row", want);
               else if (rsp_data.last_pixel !== want.last_pixel)
                  report("last_pixel", want);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      rsp_type last_1x1;
      int      k;
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cols_reg  = RST_COLS;
      rows_reg  = RST_ROWS;
      minr_reg  = RST_MINR;
      minn_reg  = RST_MINN;
      tol_reg   = RST_TOL;
      raster_pos  = 0;
      reading_out = 1'b0;
      mismatches  = 0;
      pixels_checked = 0;
      filled_seen = 0;
      points_sent = 0;
      tx_idle_pct = 21;
      rx_idle_pct = 60;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // ---- directed table ----
      // 5x4 image, range gate at its maximum, one measured neighbour fills, zero spread
      add_reg(CSR_COLS, 5);
      add_reg(CSR_ROWS, 4);
      add_reg(CSR_MINR, 32'hFFFF_FFFF);
      add_reg(CSR_MINN, 0);
      add_reg(CSR_TOL, 0);
      // farthest depth at column 4, lidar at its positive extreme
      add_req(raw_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 40'd33554428, 40'd0, 24'h7FFFFF));
      // z-buffer on cell (2,1): first, tie, nearer, farther
      add_req(raw_point(24'h800000, 24'h800000, 24'h800000, 40'd2000, 40'd1000, 24'd1000));
      add_req(raw_point(24'h7FFFFF, 24'd0, 24'd0, 40'd2000, 40'd1000, 24'd1000));
      add_req(raw_point(24'h7FFFFF, 24'd0, 24'd0, 40'd1800, 40'd900, 24'd900));
      add_req(raw_point(24'h7FFFFF, 24'd0, 24'd0, 40'd1900, 40'd950, 24'd950));
      // not finite, inside minimum range, zero depth, negative depth
      add_req(raw_point(24'h7FFFFF, 24'd0, 24'd0, 40'd300, 40'd300, 24'd100, 1'b0));
      add_req(raw_point(24'd1, 24'd0, 24'd0, 40'd300, 40'd300, 24'd100));
      add_req(raw_point(24'h7FFFFF, 24'd0, 24'd0, 40'd0, 40'd0, 24'd0));
      add_req(raw_point(24'h7FFFFF, 24'd0, 24'd0, 40'h7F_FFFF_FFFF, 40'h80_0000_0000,
                        24'h800000));
      // half rounds away from zero: 1.5 -> 2, 2.5 -> 3, -0.5 -> -1 (off image)
      add_req(raw_point(24'h7FFFFF, 24'd0, 24'd0, 40'd3, 40'd5, 24'd2));
      add_req(raw_point(24'h7FFFFF, 24'd0, 24'd0, -40'sd1, 40'd0, 24'd2));
      // off image: huge column, negative row, column equal to width
      add_req(raw_point(24'h7FFFFF, 24'd0, 24'd0, 40'h7F_FFFF_FFFF, 40'd0, 24'd1));
      add_req(raw_point(24'h7FFFFF, 24'd0, 24'd0, 40'd0, 40'h80_0000_0000, 24'd7));
      add_req(raw_point(24'h7FFFFF, 24'd0, 24'd0, 40'd500, 40'd0, 24'd100));
      // readout starts; the load in between must be ignored
      add_req(read_req());
      add_req(raw_point(24'h7FFFFF, 24'd0, 24'd0, 40'd0, 40'd0, 24'd50));
      for (k = 1; k < 16; k++)
         add_req(read_req());
      // size grows to the clamp mid-readout, then collapses to 1x1
      add_reg(CSR_COLS, 32'h3FF);
      add_reg(CSR_ROWS, 32'h3FF);
      add_req(read_req());
      add_reg(CSR_COLS, 0);
      add_reg(CSR_ROWS, 0);
      last_1x1 = '0;
      last_1x1.last_pixel = 1'b1;
      add_req(read_req(), 1'b1, last_1x1);

      foreach (steps[k]) begin
         if (steps[k].is_reg) begin
            wait_quiet();
            write_reg(steps[k].idx, steps[k].val);
         end else begin
            send_req(steps[k].pt, steps[k].typed, steps[k].want);
         end
      end

      // ---- random images ----
      run_image($urandom_range(12, 24), $urandom_range(8, 16), 520, $urandom,
                4'($urandom_range(0, 8)), 23'($urandom_range(0, 1000)));
      run_image($urandom_range(10, 20), $urandom_range(6, 12), 520, 32'hFFFF_FFFF,
                4'($urandom_range(1, 4)), 23'h7FFFFF);
      run_image($urandom_range(4, 16), $urandom_range(2, 10), 360, 32'd0,
                4'd8, 23'($urandom_range(0, 300)));

      drain_pixels();
      repeat (200) @(posedge clock);
      $display("Run covered %0d request transactions over three random images and a directed set;",
               points_sent);
      $display("%0d pixels checked, %0d of them hole-filled.", pixels_checked, filled_seen);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d pixels never came", mismatches, expected_pixels.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Run limit: five store clears plus stalled traffic come to about 15 ms.
   initial begin
      #60ms;
      $display("Timeout, %0d pixels still outstanding", expected_pixels.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
